@@ rtl/dlps_pkg.sv @@
// Shared widths, register codes and window constants of the delay-line pitch shifter.
package dlps_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PSTEP_W    = 20;
  localparam int FRAC_W     = 16;
  localparam int WIN_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam logic [WIN_W:0]   WIN_ONE     = 17'd32768;
  localparam logic [PSTEP_W-1:0] PSTEP_RESET = 20'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_STEP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 4'd1;

  // Window generation: Q30 Taylor series of the sine.
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam int unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

endpackage

@@ rtl/delay_line_pitch_shifter_unit.sv @@
// Top level of the two-tap crossfading delay-line pitch shifter.
// An accepted input item goes through the RAM read, multiply and mix registers to out_tvalid.
// Throughput: one item per cycle unless out_tready stalls; two RAM reads, a write if enabled.
// Reset (rst_n low, synchronous) clears the pointers, the fill flag and the pipeline, and sets
// pitch_step to 65536 and enable to 1. No clearing pass runs: RAM entries not yet written
// since reset are tracked by the fill flag and the write pointer and read as zero.
module delay_line_pitch_shifter_unit #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream. in_tdata: sample_in [15:0].
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dlps_pkg::SAMPLE_W-1:0]   in_tdata,
  // Result stream. out_tdata: sample_out [15:0].
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dlps_pkg::SAMPLE_W-1:0]   out_tdata,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dlps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW      = $clog2(BUFFER_DEPTH);
  localparam int HALF    = BUFFER_DEPTH / 2;
  localparam int DIST_W  = $clog2(HALF + 1);
  localparam int PHASE_W = AW + dlps_pkg::FRAC_W;
  localparam int WIN_W   = dlps_pkg::WIN_W;
  localparam int SW      = dlps_pkg::SAMPLE_W;

  localparam logic [PHASE_W:0]        SPAN    = (PHASE_W + 1)'(64'(BUFFER_DEPTH) << 16);
  localparam logic signed [AW+1:0]    DEPTH_S = (AW + 2)'(BUFFER_DEPTH);
  localparam logic signed [AW+1:0]    HALF_S  = (AW + 2)'(HALF);
  localparam logic [AW:0]             DEPTH_U = (AW + 1)'(BUFFER_DEPTH);
  localparam logic [AW:0]             HALF_U  = (AW + 1)'(HALF);
  localparam logic [AW-1:0]           LAST_WI = AW'(BUFFER_DEPTH - 1);

  // Entry i of the window is round(sin(i*pi/BUFFER_DEPTH) * 32768), built at elaboration.
  function automatic logic [WIN_W-1:0] sine_q15(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] r;
    x  = (64'(idx) * dlps_pkg::PI_Q30) / 64'(BUFFER_DEPTH);
    x2 = (x * x) >> 30;
    t  = dlps_pkg::ONE_Q30;
    for (int k = 0; k < 6; k++) begin
      p = ((x2 * t) >> 30) / 64'(dlps_pkg::TAYLOR_DIV[k]);
      t = (p >= dlps_pkg::ONE_Q30) ? 64'd0 : dlps_pkg::ONE_Q30 - p;
    end
    s = (x * t) >> 30;
    r = (s + 64'd16384) >> 15;
    if (r > 64'(dlps_pkg::WIN_ONE)) begin
      r = 64'(dlps_pkg::WIN_ONE);
    end
    return r[WIN_W-1:0];
  endfunction

  function automatic logic [HALF:0][WIN_W-1:0] build_win();
    logic [HALF:0][WIN_W-1:0] tab;
    for (int i = 0; i <= HALF; i++) begin
      tab[i] = sine_q15(i);
    end
    return tab;
  endfunction

  localparam logic [HALF:0][WIN_W-1:0] WIN_TABLE = build_win();

  // Configuration registers.
  logic [dlps_pkg::PSTEP_W-1:0] pitch_step_r;
  logic                         enable_r;

  // Pointer state. filled_r is set once the write pointer has wrapped, after which every
  // RAM entry holds a written sample; before that only entries below the pointer do.
  logic [AW-1:0]      write_index_r, write_index_nxt;
  logic [PHASE_W-1:0] read_phase_r,  read_phase_nxt;
  logic               filled_r,      filled_nxt;

  // Pipeline stage 1: RAM read data, window weight, tap valid flags.
  logic                v1_r, en1_r, tva1_r, tvb1_r;
  logic [WIN_W-1:0]    win1_r;
  logic [SW-1:0]       rd_a, rd_b;
  // Pipeline stage 2: the two weighted taps.
  logic                v2_r, en2_r;
  logic signed [SW+WIN_W:0] p1_r, p2_r;
  // Output register.
  logic                out_valid_r;
  logic [SW-1:0]       out_data_r;

  // Elastic handshakes: each stage moves when the one after it is empty or moving.
  logic adv_out, adv2, adv1, in_acc, proc;
  assign adv_out   = !out_valid_r || out_tready;
  assign adv2      = !v2_r || adv_out;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;
  assign in_acc    = in_tvalid && adv1;
  assign proc      = in_acc && enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_step_r <= dlps_pkg::PSTEP_RESET;
      enable_r     <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        dlps_pkg::REG_PITCH_STEP: pitch_step_r <= cfg_data[dlps_pkg::PSTEP_W-1:0];
        dlps_pkg::REG_ENABLE:     enable_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 0: tap addresses, circular distance to the write pointer, window lookup.
  logic [AW-1:0]         ip1;
  logic [AW:0]           ip3_sum;
  logic [AW-1:0]         ip3;
  logic                  frac_nz;
  logic signed [AW+1:0]  a_s, d_s;
  logic [DIST_W-1:0]     win_idx;
  logic                  tva, tvb;

  assign ip1     = read_phase_r[PHASE_W-1:dlps_pkg::FRAC_W];
  assign frac_nz = |read_phase_r[dlps_pkg::FRAC_W-1:0];
  assign ip3_sum = {1'b0, ip1} + HALF_U;
  assign ip3     = (ip3_sum >= DEPTH_U) ? AW'(ip3_sum - DEPTH_U) : ip3_sum[AW-1:0];
  assign tva     = filled_r || (ip1 < write_index_r);
  assign tvb     = filled_r || (ip3 < write_index_r);

  // The phase has a zero fraction against the write pointer, so the truncated distance works
  // on integer parts; a nonzero fraction takes one off wherever the phase is subtracted.
  always_comb begin
    a_s = $signed({2'b00, ip1}) - $signed({2'b00, write_index_r});
    if (!a_s[AW+1]) begin
      d_s = a_s;
      if (d_s > HALF_S) begin
        d_s = DEPTH_S - a_s - $signed({{(AW+1){1'b0}}, frac_nz});
      end
    end else begin
      d_s = -a_s - $signed({{(AW+1){1'b0}}, frac_nz});
      if (d_s > HALF_S) begin
        d_s = DEPTH_S + a_s;
      end
    end
    if (d_s > HALF_S) begin
      d_s = HALF_S;
    end
    win_idx = d_s[DIST_W-1:0];
  end

  // Pointer updates; a disabled item leaves everything as it is.
  logic [PHASE_W:0] phase_sum;
  assign phase_sum = {1'b0, read_phase_r} + (PHASE_W + 1)'(pitch_step_r);

  always_comb begin
    write_index_nxt = write_index_r;
    read_phase_nxt  = read_phase_r;
    filled_nxt      = filled_r;
    if (proc) begin
      if (write_index_r == LAST_WI) begin
        write_index_nxt = '0;
        filled_nxt      = 1'b1;
      end else begin
        write_index_nxt = write_index_r + AW'(1);
      end
      read_phase_nxt = (phase_sum >= SPAN) ? PHASE_W'(phase_sum - SPAN)
                                           : phase_sum[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_index_r <= '0;
      read_phase_r  <= '0;
      filled_r      <= 1'b0;
    end else begin
      write_index_r <= write_index_nxt;
      read_phase_r  <= read_phase_nxt;
      filled_r      <= filled_nxt;
    end
  end

  // Both taps are read in the accept cycle and see the RAM before this item's write.
  dlps_ram #(
    .DATA_W (SW),
    .DEPTH  (BUFFER_DEPTH)
  ) u_delay_ram (
    .clk     (clk),
    .we      (proc),
    .waddr   (write_index_r),
    .wdata   (in_tdata),
    .re      (adv1),
    .raddr_a (ip1),
    .raddr_b (ip3),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      en1_r  <= enable_r;
      tva1_r <= tva;
      tvb1_r <= tvb;
      win1_r <= WIN_TABLE[win_idx];
    end
  end

  // Stage 1: weight the taps. Entries never written since reset count as zero.
  logic signed [SW-1:0] tap1, tap3;
  logic [WIN_W-1:0]     wcomp;
  assign tap1  = tva1_r ? $signed(rd_a) : '0;
  assign tap3  = tvb1_r ? $signed(rd_b) : '0;
  assign wcomp = WIN_W'(dlps_pkg::WIN_ONE - {1'b0, win1_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      en2_r <= en1_r;
      p1_r  <= $signed({1'b0, win1_r}) * tap1;
      p2_r  <= $signed({1'b0, wcomp}) * tap3;
    end
  end

  // Stage 2: sum, round half up, shift by 15 and saturate to 16 bits.
  logic signed [SW+WIN_W+1:0] acc, acc_rnd;
  logic signed [SW+WIN_W+1:0] y;
  logic [SW-1:0]              y_sat;
  localparam logic signed [SW+WIN_W+1:0] RND   = (SW + WIN_W + 2)'(16384);
  localparam logic signed [SW+WIN_W+1:0] Y_MAX = (SW + WIN_W + 2)'(32767);
  localparam logic signed [SW+WIN_W+1:0] Y_MIN = -(SW + WIN_W + 2)'(32768);

  always_comb begin
    acc     = (SW + WIN_W + 2)'(p1_r) + (SW + WIN_W + 2)'(p2_r);
    acc_rnd = acc + RND;
    y       = acc_rnd >>> 15;
    if (y > Y_MAX) begin
      y_sat = 16'h7FFF;
    end else if (y < Y_MIN) begin
      y_sat = 16'h8000;
    end else begin
      y_sat = y[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_data_r <= en2_r ? y_sat : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The read phase always stays inside the buffer span.
  assert property (@(posedge clk) disable iff (!rst_n) {1'b0, read_phase_r} < SPAN)
    else $error("read phase left the buffer span");

  // A disabled item freezes the pointers.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !enable_r) |=> ($stable(write_index_r) && $stable(read_phase_r)))
    else $error("disabled item moved the pointers");

  // Wrapping the write pointer marks the whole buffer as written.
  assert property (@(posedge clk) disable iff (!rst_n)
    (proc && write_index_r == LAST_WI) |=> (filled_r && write_index_r == '0))
    else $error("write pointer wrap did not set the fill flag");

  // With every stage holding an item while the output stalls, the input stays closed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted into a full pipeline");

endmodule

@@ rtl/dlps_ram.sv @@
// Generic synchronous RAM with one write port and two registered read ports.
module dlps_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Reads return the contents from before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
